/* rtl/qpsht_pkg.sv */
// ----------------------------------------------------------------------------
// qpsht_pkg
// Shared types and constants of the string hash table with triangular probing.
// ----------------------------------------------------------------------------
package qpsht_pkg;

   localparam int TableSize = 64;
   localparam int MaxKeyLen = 20;
   localparam int SlotW     = $clog2(TableSize);
   localparam int SizeW     = 7;
   localparam int LenW      = 5;
   localparam int CharW     = 7;
   localparam int HashW     = 32;
   localparam int CsrIdxW   = 1;
   localparam int CsrDataW  = 32;
   localparam int StoreDepth = TableSize * MaxKeyLen;
   localparam int StoreAddrW = $clog2(StoreDepth);
   localparam int CharIdxW   = $clog2(MaxKeyLen);

   localparam logic [CsrIdxW-1:0] CSR_TABLE_SIZE = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_HASH_MULT  = 1'b1;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef struct packed {
      logic             op;
      logic [CharW-1:0] key_char;
      logic             last_char;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [SlotW-1:0] slot;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_MOD,
      ST_PROBE,
      ST_CMP_LEN,
      ST_CMP_RD,
      ST_CMP_CHK,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

/* rtl/quadratic_probe_string_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// quadratic_probe_string_hash_table_unit
// Open-addressed string hash table with triangular probing.
// ----------------------------------------------------------------------------
// A key character that is not the last one is taken and then goes through
// the hash multiply. The last character then adds the bit-serial remainder
// and the probing. A probe of a free slot, or of a used slot on an insert,
// is settled in the probe state; a search of a used slot reads the stored
// length, then reads and compares the key character by character, and ends
// when the whole key matches. An insert writes one character per cycle, and
// the done state ends the key. Busy is high the whole time. A search result
// is shown for one cycle with rsp_valid; it cannot be held off.
// ----------------------------------------------------------------------------
module quadratic_probe_string_hash_table_unit
   import qpsht_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [SizeW-1:0]  size_ff;
   logic [HashW-1:0]  mult_ff;
   logic [HashW-1:0]  hash_ff, hash_in;
   logic [LenW-1:0]   ilen_ff, ilen_in;
   logic [CharW-1:0]  ichr_ff [MaxKeyLen];
   logic [CharW-1:0]  char_ff;
   logic              op_ff, last_ff;
   logic              keep;
   logic [SizeW-1:0]  eff_size;
   logic [SizeW-1:0]  pos_ff, pos_in;
   logic [SizeW-1:0]  step_ff, step_in;
   logic [SizeW-1:0]  cnt_ff, cnt_in;
   logic [LenW-1:0]   ci_ff, ci_in;
   logic              fnd_ff, fnd_in;
   logic [SlotW-1:0]  where_ff, where_in;
   logic              mod_done;
   logic [SizeW-1:0]  mod_rem;
   logic              used;
   logic [LenW-1:0]   len_rd;
   logic [CharW-1:0]  chr_rd;
   logic [SlotW-1:0]  slot;
   logic [StoreAddrW-1:0] base;
   logic [StoreAddrW-1:0] caddr;
   logic [SizeW:0]    sum;
   logic [CharIdxW-1:0] ci_idx;

   assign eff_size = (size_ff == '0) ? SizeW'(1) :
                     (size_ff > SizeW'(TableSize)) ? SizeW'(TableSize) : size_ff;
   assign keep   = ilen_ff < LenW'(MaxKeyLen);
   assign slot   = pos_ff[SlotW-1:0];
   assign base   = StoreAddrW'(slot) * StoreAddrW'(MaxKeyLen);
   assign ci_idx = ci_ff[CharIdxW-1:0];
   assign caddr  = base + StoreAddrW'(ci_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeW'(TableSize);
         mult_ff <= HashW'(31);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TABLE_SIZE: size_ff <= csr_wdata[SizeW-1:0];
            CSR_HASH_MULT:  mult_ff <= csr_wdata[HashW-1:0];
            default: ;
         endcase
      end
   end

   qpsht_modred u_mod (
      .clock(clock), .reset(reset), .start(state_ff == ST_MUL && last_ff),
      .dividend(hash_in), .divisor(eff_size), .done(mod_done), .remainder(mod_rem)
   );

   qpsht_store u_store (
      .clock(clock), .reset(reset), .slot_addr(slot),
      .used_set(state_ff == ST_WRITE && ci_ff == '0),
      .used(used),
      .len_we(state_ff == ST_WRITE && ci_ff == '0), .len_wdata(ilen_ff),
      .len_rdata(len_rd),
      .chr_we(state_ff == ST_WRITE && ci_ff < ilen_ff), .chr_waddr(caddr),
      .chr_wdata(ichr_ff[ci_idx]), .chr_raddr(caddr), .chr_rdata(chr_rd)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (start) state_in = ST_MUL;
         ST_MUL:     state_in = last_ff ? ST_MOD : ST_IDLE;
         ST_MOD:     if (mod_done) state_in = ST_PROBE;
         ST_PROBE: begin
            if (cnt_ff == eff_size) state_in = ST_DONE;
            else if (!used) state_in = (op_ff == OP_INSERT) ? ST_WRITE : ST_DONE;
            else if (op_ff == OP_SEARCH) state_in = ST_CMP_LEN;
         end
         ST_CMP_LEN: state_in = (len_rd == ilen_ff) ? ST_CMP_RD : ST_PROBE;
         ST_CMP_RD:  state_in = (ci_ff == ilen_ff) ? ST_DONE : ST_CMP_CHK;
         ST_CMP_CHK: state_in = (chr_rd == ichr_ff[ci_idx]) ? ST_CMP_RD : ST_PROBE;
         ST_WRITE:   if (ci_ff + 1'b1 >= ilen_ff) state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      hash_in  = hash_ff;
      ilen_in  = ilen_ff;
      pos_in   = pos_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      ci_in    = ci_ff;
      fnd_in   = fnd_ff;
      where_in = where_ff;
      sum      = {1'b0, pos_ff} + {1'b0, step_ff};
      unique case (state_ff)
         ST_MUL: begin
            if (keep) begin
               hash_in = mult_ff * hash_ff + HashW'(char_ff);
               ilen_in = ilen_ff + 1'b1;
            end
         end
         ST_MOD: begin
            pos_in = mod_rem; step_in = SizeW'(1); cnt_in = '0;
            fnd_in = 1'b0; where_in = '0; ci_in = '0;
         end
         ST_PROBE: begin
            ci_in = '0;
         end
         ST_CMP_LEN, ST_CMP_CHK: begin
            if (state_in == ST_PROBE) begin
               if (sum >= {1'b0, eff_size}) sum = sum - {1'b0, eff_size};
               pos_in  = sum[SizeW-1:0];
               step_in = (step_ff + 1'b1 == eff_size) ? '0 : step_ff + 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
            if (state_ff == ST_CMP_CHK) ci_in = ci_ff + 1'b1;
         end
         ST_CMP_RD: begin
            if (ci_ff == ilen_ff) begin fnd_in = 1'b1; where_in = slot; end
         end
         ST_WRITE:  ci_in = ci_ff + 1'b1;
         ST_DONE: begin hash_in = '0; ilen_in = '0; end
         default: ;
      endcase
      if (state_ff == ST_PROBE && used && op_ff == OP_INSERT && cnt_ff != eff_size) begin
         if (sum >= {1'b0, eff_size}) sum = sum - {1'b0, eff_size};
         pos_in  = sum[SizeW-1:0];
         step_in = (step_ff + 1'b1 == eff_size) ? '0 : step_ff + 1'b1;
         cnt_in  = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hash_ff  <= '0;
         ilen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         ilen_ff  <= ilen_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      step_ff  <= step_in;
      cnt_ff   <= cnt_in;
      ci_ff    <= ci_in;
      fnd_ff   <= fnd_in;
      where_ff <= where_in;
      if (state_ff == ST_IDLE && start) begin
         char_ff <= req_data.key_char;
         op_ff   <= req_data.op;
         last_ff <= req_data.last_char;
      end
      if (state_ff == ST_MUL && keep) ichr_ff[ilen_ff[CharIdxW-1:0]] <= char_ff;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_DONE && op_ff == OP_SEARCH;
   assign rsp_data  = '{found: fnd_ff, slot: where_ff};

endmodule

/* rtl/qpsht_modred.sv */
// ----------------------------------------------------------------------------
// qpsht_modred
// Restoring remainder unit: reduces a 32-bit hash modulo the table size,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qpsht_modred
   import qpsht_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [HashW-1:0] dividend,
   input  logic [SizeW-1:0] divisor,
   output logic             done,
   output logic [SizeW-1:0] remainder
);

   localparam int CntW = $clog2(HashW + 1);

   logic [HashW-1:0] shift_ff, shift_in;
   logic [SizeW:0]   rem_ff, rem_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [SizeW:0]   trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      trial    = {rem_ff[SizeW-1:0], shift_ff[HashW-1]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = CntW'(HashW);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[HashW-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) rem_in = trial - {1'b0, divisor};
         else rem_in = trial;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign done      = busy_ff && (cnt_ff == CntW'(1));
   assign remainder = rem_in[SizeW-1:0];

endmodule

/* rtl/qpsht_store.sv */
// ----------------------------------------------------------------------------
// qpsht_store
// Key storage: stored characters, stored lengths and occupancy bits.
// ----------------------------------------------------------------------------
module qpsht_store
   import qpsht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [SlotW-1:0]      slot_addr,
   input  logic                  used_set,
   output logic                  used,
   input  logic                  len_we,
   input  logic [LenW-1:0]       len_wdata,
   output logic [LenW-1:0]       len_rdata,
   input  logic                  chr_we,
   input  logic [StoreAddrW-1:0] chr_waddr,
   input  logic [CharW-1:0]      chr_wdata,
   input  logic [StoreAddrW-1:0] chr_raddr,
   output logic [CharW-1:0]      chr_rdata
);

   logic [TableSize-1:0] used_ff;
   logic [LenW-1:0]      len_mem [TableSize];
   logic [CharW-1:0]     chr_mem [StoreDepth];

   always_ff @(posedge clock) begin
      if (reset) used_ff <= '0;
      else if (used_set) used_ff[slot_addr] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (len_we) len_mem[slot_addr] <= len_wdata;
      len_rdata <= len_mem[slot_addr];
   end

   always_ff @(posedge clock) begin
      if (chr_we) chr_mem[chr_waddr] <= chr_wdata;
      chr_rdata <= chr_mem[chr_raddr];
   end

   assign used = used_ff[slot_addr];

endmodule

/* rtl/qpsht_checker.sv */
// ----------------------------------------------------------------------------
// qpsht_checker
// Port-level checks of the string hash table.
// ----------------------------------------------------------------------------
module qpsht_checker
   import qpsht_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start not taken");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result lasted two cycles");
   a_rsp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.slot == '0)
      else $error("slot set on miss");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");

endmodule

bind quadratic_probe_string_hash_table_unit qpsht_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

/* verif/quadratic_probe_string_hash_table_unit_checker.sv */
// ----------------------------------------------------------------------------
// quadratic_probe_string_hash_table_unit_checker
// Watches the request, result and register ports of the string hash table,
// keeps its own copy of the table, and checks every search result in order.
// ----------------------------------------------------------------------------
module quadratic_probe_string_hash_table_unit_checker
   import qpsht_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  req_type             req_data,
   input  logic                rsp_valid,
   input  rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int                  fail_count,
   output int                  pending,
   output int                  search_count,
   output int                  hit_count,
   output int                  insert_count
);

   logic [SizeW-1:0] size_reg;
   logic [HashW-1:0] mult_reg;
   logic             occupied [TableSize];
   logic [CharW-1:0] slot_key [TableSize][MaxKeyLen];
   int               slot_len [TableSize];
   logic [CharW-1:0] key_buf [MaxKeyLen];
   int               key_len;
   logic [HashW-1:0] key_hash;
   rsp_type          lookup_queue [$];

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic int probe_size();
      int s;
      s = size_reg;
      if (s == 0) s = 1;
      if (s > TableSize) s = TableSize;
      return s;
   endfunction

   function automatic bit key_matches(input int x);
      if (slot_len[x] != key_len) return 0;
      for (int k = 0; k < key_len; k++)
         if (slot_key[x][k] != key_buf[k]) return 0;
      return 1;
   endfunction

   task automatic take_char(input req_type r);
      int      s;
      int      home;
      int      x;
      rsp_type e;
      if (key_len < MaxKeyLen) begin
         key_buf[key_len] = r.key_char;
         key_len++;
         key_hash = mult_reg * key_hash + HashW'(r.key_char);
      end
      if (!r.last_char) return;
      s = probe_size();
      home = key_hash % s;
      e = '0;
      if (r.op == OP_INSERT) begin
         insert_count++;
         for (int i = 0; i < s; i++) begin
            x = (home + (i + i * i) / 2) % s;
            if (!occupied[x]) begin
               occupied[x] = 1'b1;
               slot_len[x] = key_len;
               for (int k = 0; k < key_len; k++) slot_key[x][k] = key_buf[k];
               break;
            end
         end
      end else begin
         for (int i = 0; i < s; i++) begin
            x = (home + (i + i * i) / 2) % s;
            if (!occupied[x]) break;
            if (key_matches(x)) begin
               e.found = 1'b1;
               e.slot = SlotW'(x);
               break;
            end
         end
         lookup_queue.push_back(e);
      end
      key_len = 0;
      key_hash = '0;
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         size_reg = SizeW'(TableSize);
         mult_reg = 32'd31;
         for (int i = 0; i < TableSize; i++) occupied[i] = 1'b0;
         key_len = 0;
         key_hash = '0;
         lookup_queue.delete();
      end else begin
         if (rsp_valid) begin
            if (lookup_queue.size() == 0) begin
               report("search result with no search outstanding");
            end else begin
               e = lookup_queue.pop_front();
               if (rsp_data.found !== e.found)
                  report($sformatf("found %b, expected %b", rsp_data.found, e.found));
               if (rsp_data.slot !== e.slot)
                  report($sformatf("slot %0d, expected %0d", rsp_data.slot, e.slot));
               if (e.found) hit_count++;
               search_count++;
            end
         end
         if (start && !busy) take_char(req_data);
         if (csr_we) begin
            if (csr_index == CSR_TABLE_SIZE) size_reg = csr_wdata[SizeW-1:0];
            else if (csr_index == CSR_HASH_MULT) mult_reg = csr_wdata;
         end
      end
      pending = lookup_queue.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      search_count = 0;
      hit_count = 0;
      insert_count = 0;
   end

endmodule

/* verif/quadratic_probe_string_hash_table_unit_test.sv */
// ----------------------------------------------------------------------------
// quadratic_probe_string_hash_table_unit_test
// Feeds insert and search keys one character at a time through several table
// sizes and hash multipliers, in bursts with random gaps, and lets the
// checker compare each search result against its own table.
// ----------------------------------------------------------------------------
module quadratic_probe_string_hash_table_unit_test;
   import qpsht_pkg::*;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;
   int                  fail_count;
   int                  pending;
   int                  search_count;
   int                  hit_count;
   int                  insert_count;

   int               char_count;
   int               burst_left;
   logic [CharW-1:0] word_chars [16][24];
   int               word_len [16];
   logic [CharW-1:0] key_chars [24];

   quadratic_probe_string_hash_table_unit dut (.*);

   quadratic_probe_string_hash_table_unit_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   task automatic send_char(input logic op, input logic [CharW-1:0] ch, input logic last);
      if (burst_left == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      start = 1'b1;
      req_data.op = op;
      req_data.key_char = ch;
      req_data.last_char = last;
      do @(posedge clock); while (busy);
      @(negedge clock);
      char_count++;
      burst_left--;
   endtask

   task automatic send_key(input logic op, input int len, input bit mixed);
      for (int i = 0; i < len; i++)
         send_char(mixed ? logic'($urandom_range(0, 1)) : op, key_chars[i], i == len - 1);
   endtask

   task automatic send_word(input logic op, input int w);
      for (int i = 0; i < word_len[w]; i++) key_chars[i] = word_chars[w][i];
      send_key(op, word_len[w], 0);
   endtask

   task automatic quiesce();
      start = 1'b0;
      wait (pending == 0);
      do @(posedge clock); while (busy);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] val);
      quiesce();
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic random_phase(input int chars);
      int target;
      int w;
      int len;
      target = char_count + chars;
      while (char_count < target) begin
         w = $urandom_range(0, 15);
         case ($urandom_range(0, 9))
            0, 1, 2: send_word(OP_INSERT, w);
            3, 4, 5, 6: send_word(OP_SEARCH, w);
            default: begin
               len = $urandom_range(1, 24);
               for (int i = 0; i < len; i++) key_chars[i] = CharW'($urandom_range(0, 127));
               send_key(logic'($urandom_range(0, 1)), len, $urandom_range(0, 3) == 0);
            end
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      char_count = 0;
      burst_left = 0;
      for (int w = 0; w < 16; w++) begin
         word_len[w] = (w < 2) ? $urandom_range(19, 24) : $urandom_range(1, 5);
         for (int i = 0; i < 24; i++) word_chars[w][i] = CharW'($urandom_range(0, 127));
      end
      repeat (7) @(negedge clock);
      reset = 1'b0;

      key_chars[0] = 7'd65;
      send_key(OP_INSERT, 1, 0);
      send_key(OP_SEARCH, 1, 0);
      send_key(OP_INSERT, 1, 0);
      key_chars[0] = 7'd66;
      send_key(OP_SEARCH, 1, 0);
      key_chars[0] = 7'd0;
      key_chars[1] = 7'd127;
      send_key(OP_INSERT, 2, 0);
      send_key(OP_SEARCH, 2, 0);
      for (int i = 0; i < 22; i++) key_chars[i] = CharW'(i * 5 + 1);
      send_key(OP_INSERT, 22, 0);
      send_key(OP_SEARCH, 20, 0);
      send_key(OP_SEARCH, 1, 1);

      start = 1'b0;
      wait (pending == 0);
      repeat (300) @(negedge clock);

      random_phase(500);
      write_reg(CSR_TABLE_SIZE, 32'd1);
      random_phase(120);
      write_reg(CSR_TABLE_SIZE, 32'd0);
      write_reg(CSR_HASH_MULT, 32'd0);
      random_phase(120);
      write_reg(CSR_TABLE_SIZE, 32'd5);
      write_reg(CSR_HASH_MULT, 32'hFFFF_FFFF);
      random_phase(200);
      write_reg(CSR_TABLE_SIZE, 32'd127);
      write_reg(CSR_HASH_MULT, 32'd131);
      random_phase(300);
      write_reg(CSR_TABLE_SIZE, 32'd64);
      write_reg(CSR_HASH_MULT, $urandom);
      random_phase(400);

      quiesce();
      repeat (50) @(negedge clock);
      $display("%0d key characters sent: %0d inserts, %0d searches, %0d hits,",
               char_count, insert_count, search_count, hit_count);
      $display("across table sizes 0, 1, 5, 64 and 127 and several multipliers.");
      if (fail_count == 0) begin
         $display("quadratic_probe_string_hash_table_unit_test OK");
      end else begin
         $display("quadratic_probe_string_hash_table_unit_test NOT OK");
      end
      $finish;
   end

   initial begin
      #200000000;
      $display("timeout at %0t", $time);
      $display("quadratic_probe_string_hash_table_unit_test NOT OK");
      $finish;
   end

endmodule

/* sim.f */
rtl/qpsht_pkg.sv
rtl/qpsht_modred.sv
rtl/qpsht_store.sv
rtl/quadratic_probe_string_hash_table_unit.sv
rtl/qpsht_checker.sv
verif/quadratic_probe_string_hash_table_unit_checker.sv
verif/quadratic_probe_string_hash_table_unit_test.sv
